FILE: hdl/bir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bir_pkg;

    // field widths fixed by the register map and the transaction fields
    localparam int CFG_W   = 11;
    localparam int COORD_W = 10;
    localparam int NUM_W   = COORD_W + CFG_W;
    localparam int RAT_W   = 10;
    localparam int ADDR_W  = 4;

    // operation codes
    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // register indexes
    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } t_reg_idx;

    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;
    localparam logic [CFG_W-1:0] SIZE_MIN   = 11'd2;

endpackage

`default_nettype wire

FILE: hdl/binary_image_idw_resize_top.sv
`timescale 1ns / 1ps
`default_nettype none

// One-bit image resizer with inverse distance weighting. A transaction with
// i_operation = store writes i_pixel_in into the on-chip source bitmap and
// gives no result; busy stays low. A compute transaction maps destination
// pixel (i_col, i_row) onto the source grid end to end, reads the four
// neighbour pixels from the bitmap, weights each by 1/(dd + distance) and puts
// out o_pixel_out = 1 when the weighted mean is at least one half, or passes
// the pixel through if dd and distance are both zero. The result is flagged
// by o_valid, high for exactly one cycle, and the receiver cannot hold it
// off. The work is done in one shared bit-serial divider (six divisions of
// the mapping plus one reciprocal per neighbour, one quotient bit a cycle)
// and one shared digit-by-digit square root unit (five roots, one root bit a
// cycle); the four pixel reads go in turn through the single bitmap read
// port. The bitmap holds nothing defined until written. Sizes are to be set
// through the APB-style port only while the block is idle, which the block
// does not enforce, and are used clamped to 2..MAX_WIDTH / MAX_HEIGHT.
module binary_image_idw_resize_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int FRAC_BITS  = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // command channel
    input  wire                            start,
    output logic                           busy,
    input  wire                            i_operation,
    input  wire  [bir_pkg::COORD_W-1:0]    i_col,
    input  wire  [bir_pkg::COORD_W-1:0]    i_row,
    input  wire                            i_pixel_in,
    // result strobe
    output logic                           o_valid,
    output logic                           o_pixel_out,
    // configuration port
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [bir_pkg::ADDR_W-1:0]     paddr,
    input  wire  [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int F     = FRAC_BITS;
    localparam int DW    = F + 33;            // dividend / quotient bits
    localparam int VW    = F + 12;            // divisor bits
    localparam int SR    = F + 11;            // square root result bits
    localparam int SV    = 2 * SR;            // square root operand bits
    localparam int ACCW  = F + 35;            // weight sums
    localparam int DCW   = $clog2(DW + 1);
    localparam int SCW   = $clog2(SR + 1);
    localparam int MW    = bir_pkg::CFG_W + F;
    localparam int SQW   = 2 * F + 2;         // squared offsets
    localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    localparam int CW = bir_pkg::CFG_W;
    localparam int XW = bir_pkg::COORD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MAPX, S_FX, S_MAPY, S_FY, S_RAT, S_RATY, S_Q, S_DD,
        S_DDCAP, S_RD, S_RDW, S_OFF, S_SQ, S_WT, S_ACC
    } t_state;

    typedef enum logic {
        U_DIV, U_SQRT
    } t_unit;

    // configuration registers
    logic [CW-1:0] r_cfg_sw, r_cfg_sh, r_cfg_dw, r_cfg_dh;
    logic          w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sw <= bir_pkg::SIZE_RESET;
            r_cfg_sh <= bir_pkg::SIZE_RESET;
            r_cfg_dw <= bir_pkg::SIZE_RESET;
            r_cfg_dh <= bir_pkg::SIZE_RESET;
        end else if (w_cfg_we) begin
            case (bir_pkg::t_reg_idx'(paddr[3:2]))
                bir_pkg::REG_SRC_WIDTH:  r_cfg_sw <= pwdata[CW-1:0];
                bir_pkg::REG_SRC_HEIGHT: r_cfg_sh <= pwdata[CW-1:0];
                bir_pkg::REG_DST_WIDTH:  r_cfg_dw <= pwdata[CW-1:0];
                bir_pkg::REG_DST_HEIGHT: r_cfg_dh <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (bir_pkg::t_reg_idx'(paddr[3:2]))
            bir_pkg::REG_SRC_WIDTH:  prdata = 32'(r_cfg_sw);
            bir_pkg::REG_SRC_HEIGHT: prdata = 32'(r_cfg_sh);
            bir_pkg::REG_DST_WIDTH:  prdata = 32'(r_cfg_dw);
            bir_pkg::REG_DST_HEIGHT: prdata = 32'(r_cfg_dh);
            default:                 prdata = '0;
        endcase
    end

    // size clamp to 2..hi
    function automatic logic [CW-1:0] clamp_size(input logic [CW-1:0] v, input int hi);
        logic [CW-1:0] res;
        if (v < bir_pkg::SIZE_MIN)     res = bir_pkg::SIZE_MIN;
        else if (32'(v) > 32'(hi))     res = CW'(hi);
        else                           res = v;
        return res;
    endfunction

    logic [CW-1:0] w_sw, w_sh, w_dw, w_dh;
    logic [XW-1:0] w_col_sat, w_row_sat;

    assign w_sw = clamp_size(r_cfg_sw, MAX_WIDTH);
    assign w_sh = clamp_size(r_cfg_sh, MAX_HEIGHT);
    assign w_dw = clamp_size(r_cfg_dw, MAX_WIDTH);
    assign w_dh = clamp_size(r_cfg_dh, MAX_HEIGHT);
    // compute outside the destination saturates to the last row / column
    assign w_col_sat = (CW'(i_col) > w_dw - CW'(1)) ? XW'(w_dw - CW'(1)) : i_col;
    assign w_row_sat = (CW'(i_row) > w_dh - CW'(1)) ? XW'(w_dh - CW'(1)) : i_row;

    // sequencer state
    t_state           r_state, r_ret;
    logic [CW-1:0]    r_sw, r_sh, r_dw, r_dh;
    logic [XW-1:0]    r_col, r_row;
    logic [CW-1:0]    r_px, r_py;
    logic             r_xhit, r_yhit;
    logic [F-1:0]     r_fx, r_fy;
    logic [bir_pkg::RAT_W-1:0] r_rx;
    logic [2*bir_pkg::RAT_W-1:0] r_qx, r_qy;
    logic [SR-1:0]    r_dd;
    logic [1:0]       r_k;
    logic [3:0]       r_pix;
    logic [SQW-1:0]   r_oxx, r_oyy;
    logic [ACCW-1:0]  r_sum, r_acc;

    // shared bit-serial divider
    logic [DW-1:0]    r_dv_a, r_dv_q;
    logic [VW-1:0]    r_dv_d, r_dv_rem;
    logic [DCW-1:0]   r_dv_cnt;
    // shared digit-by-digit square root
    logic [SV-1:0]    r_sq_v;
    logic [SR+1:0]    r_sq_rem;
    logic [SR-1:0]    r_sq_root;
    logic [SCW-1:0]   r_sq_cnt;
    logic             r_unit_run;
    t_unit            r_unit;

    // divider step
    logic [VW:0]      w_dv_rem2;
    logic             w_dv_ge;
    logic [VW-1:0]    n_dv_rem;
    assign w_dv_rem2 = {r_dv_rem, r_dv_a[DW-1]};
    assign w_dv_ge   = w_dv_rem2 >= {1'b0, r_dv_d};
    assign n_dv_rem  = w_dv_ge ? VW'(w_dv_rem2 - {1'b0, r_dv_d}) : w_dv_rem2[VW-1:0];

    // square root step
    logic [SR+3:0]    w_sq_rem2, w_sq_trial;
    logic             w_sq_ge;
    logic [SR+1:0]    n_sq_rem;
    assign w_sq_rem2  = {r_sq_rem, r_sq_v[SV-1:SV-2]};
    assign w_sq_trial = {2'b00, r_sq_root, 2'b01};
    assign w_sq_ge    = w_sq_rem2 >= w_sq_trial;
    assign n_sq_rem   = w_sq_ge ? (SR+2)'(w_sq_rem2 - w_sq_trial) : w_sq_rem2[SR+1:0];

    // mapping products
    logic [bir_pkg::NUM_W-1:0] w_numx, w_numy;
    assign w_numx = bir_pkg::NUM_W'(r_col) * bir_pkg::NUM_W'(r_sw - CW'(1));
    assign w_numy = bir_pkg::NUM_W'(r_row) * bir_pkg::NUM_W'(r_sh - CW'(1));

    // neighbour coordinates; at an exact hit or the last column or row the next one repeats
    logic [CW-1:0] w_nx, w_ny, w_x, w_y;
    logic [F:0]    w_ox, w_oy;
    logic          w_xrep, w_yrep;
    assign w_nx   = (r_xhit || (r_px + CW'(1) >= r_sw)) ? r_px : r_px + CW'(1);
    assign w_ny   = (r_yhit || (r_py + CW'(1) >= r_sh)) ? r_py : r_py + CW'(1);
    assign w_xrep = (w_nx == r_px);
    assign w_yrep = (w_ny == r_py);
    assign w_x    = r_k[0] ? w_nx : r_px;
    assign w_y    = r_k[1] ? w_ny : r_py;
    assign w_ox   = (r_k[0] && !w_xrep) ? ONE - (F+1)'(r_fx) : (F+1)'(r_fx);
    assign w_oy   = (r_k[1] && !w_yrep) ? ONE - (F+1)'(r_fy) : (F+1)'(r_fy);

    logic [VW-1:0] w_den;
    assign w_den = VW'(r_dd) + VW'(r_sq_root);

    // source bitmap, one write and one registered read port
    logic          r_mem [DEPTH];
    logic          r_mem_q;
    logic          w_store, w_in_range;
    logic [AW-1:0] w_waddr, w_raddr;

    assign w_in_range = (32'(i_col) < 32'(MAX_WIDTH)) && (32'(i_row) < 32'(MAX_HEIGHT));
    assign w_store    = start && !busy && (i_operation == bir_pkg::OP_STORE) && w_in_range;
    assign w_waddr    = AW'(i_row) * AW'(MAX_WIDTH) + AW'(i_col);
    assign w_raddr    = AW'(w_y) * AW'(MAX_WIDTH) + AW'(w_x);

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[w_waddr] <= i_pixel_in;
        end
        r_mem_q <= r_mem[w_raddr];
    end

    assign busy = (r_state != S_IDLE) || r_unit_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_unit_run  <= 1'b0;
            r_unit      <= U_DIV;
            o_valid     <= 1'b0;
            o_pixel_out <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (r_unit_run) begin
                // a shared unit is iterating; the sequencer resumes at r_ret
                if (r_unit == U_DIV) begin
                    r_dv_rem <= n_dv_rem;
                    r_dv_q   <= {r_dv_q[DW-2:0], w_dv_ge};
                    r_dv_a   <= r_dv_a << 1;
                    r_dv_cnt <= r_dv_cnt - DCW'(1);
                    if (r_dv_cnt == DCW'(1)) begin
                        r_unit_run <= 1'b0;
                        r_state    <= r_ret;
                    end
                end else begin
                    r_sq_rem  <= n_sq_rem;
                    r_sq_root <= {r_sq_root[SR-2:0], w_sq_ge};
                    r_sq_v    <= r_sq_v << 2;
                    r_sq_cnt  <= r_sq_cnt - SCW'(1);
                    if (r_sq_cnt == SCW'(1)) begin
                        r_unit_run <= 1'b0;
                        r_state    <= r_ret;
                    end
                end
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (start && i_operation == bir_pkg::OP_COMPUTE) begin
                            r_sw    <= w_sw;
                            r_sh    <= w_sh;
                            r_dw    <= w_dw;
                            r_dh    <= w_dh;
                            r_col   <= w_col_sat;
                            r_row   <= w_row_sat;
                            r_sum   <= '0;
                            r_acc   <= '0;
                            r_state <= S_MAPX;
                        end
                    end
                    S_MAPX: begin
                        // px = col*(sw-1) / (dw-1)
                        r_dv_a     <= DW'(w_numx) << (DW - bir_pkg::NUM_W);
                        r_dv_d     <= VW'(r_dw - CW'(1));
                        r_dv_q     <= '0;
                        r_dv_rem   <= '0;
                        r_dv_cnt   <= DCW'(bir_pkg::NUM_W);
                        r_unit     <= U_DIV;
                        r_unit_run <= 1'b1;
                        r_ret      <= S_FX;
                    end
                    S_FX: begin
                        r_px       <= r_dv_q[CW-1:0];
                        r_xhit     <= (r_dv_rem == '0);
                        // fx = rem * 2^F / (dw-1)
                        r_dv_a     <= DW'({r_dv_rem[CW-1:0], {F{1'b0}}}) << (DW - MW);
                        r_dv_q     <= '0;
                        r_dv_rem   <= '0;
                        r_dv_cnt   <= DCW'(MW);
                        r_unit_run <= 1'b1;
                        r_ret      <= S_MAPY;
                    end
                    S_MAPY: begin
                        r_fx       <= r_dv_q[F-1:0];
                        r_dv_a     <= DW'(w_numy) << (DW - bir_pkg::NUM_W);
                        r_dv_d     <= VW'(r_dh - CW'(1));
                        r_dv_q     <= '0;
                        r_dv_rem   <= '0;
                        r_dv_cnt   <= DCW'(bir_pkg::NUM_W);
                        r_unit_run <= 1'b1;
                        r_ret      <= S_FY;
                    end
                    S_FY: begin
                        r_py       <= r_dv_q[CW-1:0];
                        r_yhit     <= (r_dv_rem == '0);
                        r_dv_a     <= DW'({r_dv_rem[CW-1:0], {F{1'b0}}}) << (DW - MW);
                        r_dv_q     <= '0;
                        r_dv_rem   <= '0;
                        r_dv_cnt   <= DCW'(MW);
                        r_unit_run <= 1'b1;
                        r_ret      <= S_RAT;
                    end
                    S_RAT: begin
                        r_fy       <= r_dv_q[F-1:0];
                        // integer scale ratio dw / sw
                        r_dv_a     <= DW'(r_dw) << (DW - CW);
                        r_dv_d     <= VW'(r_sw);
                        r_dv_q     <= '0;
                        r_dv_rem   <= '0;
                        r_dv_cnt   <= DCW'(CW);
                        r_unit_run <= 1'b1;
                        r_ret      <= S_RATY;
                    end
                    S_RATY: begin
                        r_rx       <= r_dv_q[bir_pkg::RAT_W-1:0];
                        r_dv_a     <= DW'(r_dh) << (DW - CW);
                        r_dv_d     <= VW'(r_sh);
                        r_dv_q     <= '0;
                        r_dv_rem   <= '0;
                        r_dv_cnt   <= DCW'(CW);
                        r_unit_run <= 1'b1;
                        r_ret      <= S_Q;
                    end
                    S_Q: begin
                        r_qx    <= (2*bir_pkg::RAT_W)'(r_rx) * (2*bir_pkg::RAT_W)'(r_rx);
                        r_qy    <= (2*bir_pkg::RAT_W)'(r_dv_q[bir_pkg::RAT_W-1:0])
                                 * (2*bir_pkg::RAT_W)'(r_dv_q[bir_pkg::RAT_W-1:0]);
                        r_state <= S_DD;
                    end
                    S_DD: begin
                        // dd = sqrt(q) with F fractional bits
                        r_sq_v     <= SV'(r_qx + r_qy) << (2 * F);
                        r_sq_rem   <= '0;
                        r_sq_root  <= '0;
                        r_sq_cnt   <= SCW'(SR);
                        r_unit     <= U_SQRT;
                        r_unit_run <= 1'b1;
                        r_ret      <= S_DDCAP;
                    end
                    S_DDCAP: begin
                        r_dd    <= r_sq_root;
                        r_k     <= '0;
                        r_state <= S_RD;
                    end
                    S_RD: begin
                        // read address for neighbour r_k is presented this cycle
                        r_state <= S_RDW;
                    end
                    S_RDW: begin
                        r_pix[r_k] <= r_mem_q;
                        r_k        <= r_k + 2'd1;
                        r_state    <= (r_k == 2'd3) ? S_OFF : S_RD;
                    end
                    S_OFF: begin
                        r_oxx   <= SQW'(w_ox) * SQW'(w_ox);
                        r_oyy   <= SQW'(w_oy) * SQW'(w_oy);
                        r_state <= S_SQ;
                    end
                    S_SQ: begin
                        r_sq_v     <= SV'(r_oxx) + SV'(r_oyy);
                        r_sq_rem   <= '0;
                        r_sq_root  <= '0;
                        r_sq_cnt   <= SCW'(SR);
                        r_unit     <= U_SQRT;
                        r_unit_run <= 1'b1;
                        r_ret      <= S_WT;
                    end
                    S_WT: begin
                        if (w_den == '0) begin
                            // zero distance and zero dd: pass the source pixel through
                            o_valid     <= 1'b1;
                            o_pixel_out <= r_pix[r_k];
                            r_state     <= S_IDLE;
                        end else begin
                            // weight = 2^(F+32) / (dd + dist)
                            r_dv_a     <= {1'b1, {(DW-1){1'b0}}};
                            r_dv_d     <= w_den;
                            r_dv_q     <= '0;
                            r_dv_rem   <= '0;
                            r_dv_cnt   <= DCW'(DW);
                            r_unit     <= U_DIV;
                            r_unit_run <= 1'b1;
                            r_ret      <= S_ACC;
                        end
                    end
                    S_ACC: begin
                        r_sum <= r_sum + ACCW'(r_dv_q);
                        if (r_pix[r_k]) begin
                            r_acc <= r_acc + ACCW'(r_dv_q);
                        end
                        if (r_k == 2'd3) begin
                            // weighted mean at least one half
                            o_valid     <= 1'b1;
                            o_pixel_out <= ({r_pix[r_k] ? r_acc + ACCW'(r_dv_q) : r_acc, 1'b0}
                                           >= {1'b0, r_sum + ACCW'(r_dv_q)});
                            r_state     <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_OFF;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    // a result strobe lasts one cycle and comes only as a compute finishes
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_valid_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result strobe without a finishing compute");

    a_store_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == bir_pkg::OP_STORE) |=> !busy && !o_valid)
        else $error("store transaction occupied the sequencer");

endmodule

`default_nettype wire
